[hw/rtl/uftl_pkg.sv]
`timescale 1ns / 1ps

package uftl_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths
    localparam int FRAG_W  = 8;
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int KEY_W   = 2 * IP_W + 2 * PORT_W;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = KEY_W + MAC_W;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 2;

    // Stream widths, whole bytes
    localparam int S_DATA_W = FRAG_W + ENTRY_W;
    localparam int M_DATA_W = 8;

    localparam logic [FRAG_W-1:0] FRAG_MASK = 8'h3f;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [MAC_W-1:0]   t_mac;
    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [SLOT_W-1:0]  t_slot;

    typedef enum logic [STAT_W-1:0] {
        ST_HIT   = 2'd0,
        ST_FREE  = 2'd1,
        ST_EVICT = 2'd2,
        ST_DROP  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_DECIDE,
        S_RESP
    } t_state;

endpackage

[hw/rtl/uftl_ram.sv]
`timescale 1ns / 1ps

module uftl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/udp_flow_table_lru.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Payload
// ---------+-----------+--------------------------------------------------------
// s_axis   | in        | tdata: frag_byte, inside_ip, inside_port, outside_ip,
//          |           |        outside_port, source_mac
// m_axis   | out       | tdata: slot (zero padded); tuser: status
//
// A dropped fragment goes from acceptance straight to the result state; any other
// header first passes the scan, tail and decide states, the scan reading one
// table entry a cycle through the key and stamp memory read ports.
// Synchronous reset clears the valid bits, the use counter and the control state;
// no clearing pass is needed. One result can wait in the output register while
// the next header is taken; the block holds its result if that register is full.

module udp_flow_table_lru (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // frag_byte, inside_ip, inside_port, outside_ip, outside_port, source_mac
    input  logic [uftl_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // slot, zero padded
    output logic [uftl_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // status
    output logic [uftl_pkg::STAT_W-1:0]   o_m_axis_tuser
);

    import uftl_pkg::*;

    localparam t_idx LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state               r_state, n_state;
    logic [ENTRIES-1:0]   r_valid;
    t_stamp               r_use_cnt, n_use_cnt;
    t_idx                 r_addr;
    t_idx                 r_chk_idx;
    t_key                 r_key;
    t_mac                 r_mac;
    logic                 r_hit_found, r_free_found;
    t_idx                 r_hit_idx, r_free_idx, r_min_idx;
    t_stamp               r_min_use;
    t_slot                r_res_slot;
    t_status              r_res_status;
    logic                 r_out_vld;
    t_slot                r_out_slot;
    t_status              r_out_status;

    logic                 w_accept;
    logic                 w_is_frag;
    logic                 w_eval;
    logic                 w_write;
    logic                 w_load_out;
    logic                 w_out_free;
    logic                 w_match;
    logic [ENTRY_W-1:0]   w_rd_entry;
    t_stamp               w_rd_use;
    t_idx                 w_sel_idx;
    t_status              w_sel_status;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_frag  = (i_s_axis_tdata[FRAG_W-1:0] & FRAG_MASK) != '0;
    assign w_out_free = !r_out_vld || i_m_axis_tready;
    assign w_match    = r_valid[r_chk_idx] && (w_rd_entry[KEY_W-1:0] == r_key);
    assign n_use_cnt  = (r_use_cnt == '1) ? r_use_cnt : r_use_cnt + 1'b1;

    // Key and MAC store
    uftl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_write && (w_sel_status != ST_HIT)),
        .i_waddr (w_sel_idx),
        .i_wdata ({r_mac, r_key}),
        .i_raddr (r_addr),
        .o_rdata (w_rd_entry)
    );

    // Last-use stamp store
    uftl_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (ENTRIES)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_waddr (w_sel_idx),
        .i_wdata (n_use_cnt),
        .i_raddr (r_addr),
        .o_rdata (w_rd_use)
    );

    // Slot choice: hit, else highest free, else oldest
    always_comb begin
        if (r_hit_found) begin
            w_sel_idx    = r_hit_idx;
            w_sel_status = ST_HIT;
        end else if (r_free_found) begin
            w_sel_idx    = r_free_idx;
            w_sel_status = ST_FREE;
        end else begin
            w_sel_idx    = r_min_idx;
            w_sel_status = ST_EVICT;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_is_frag ? S_RESP : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_RESP;
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_eval          = 1'b0;
        w_write         = 1'b0;
        w_load_out      = 1'b0;
        unique case (r_state)
            S_IDLE:   o_s_axis_tready = 1'b1;
            S_SCAN:   w_eval          = (r_addr != '0);
            S_TAIL:   w_eval          = 1'b1;
            S_DECIDE: w_write         = 1'b1;
            S_RESP:   w_load_out      = w_out_free;
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_use_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_write) begin
                r_valid[w_sel_idx] <= 1'b1;
                r_use_cnt          <= n_use_cnt;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Header capture and scan accumulators
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key        <= i_s_axis_tdata[FRAG_W +: KEY_W];
            r_mac        <= i_s_axis_tdata[FRAG_W + KEY_W +: MAC_W];
            r_addr       <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_res_slot   <= '0;
            r_res_status <= ST_DROP;
        end
        if (r_state == S_SCAN) begin
            r_chk_idx <= r_addr;
            if (r_addr != LAST_IDX) begin
                r_addr <= r_addr + 1'b1;
            end
        end
        if (w_eval) begin
            if (!r_valid[r_chk_idx]) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_chk_idx;
            end else if (!r_hit_found && w_match) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_chk_idx;
            end
            // strict compare keeps the lowest index on equal stamps
            if (r_chk_idx == '0 || w_rd_use < r_min_use) begin
                r_min_use <= w_rd_use;
                r_min_idx <= r_chk_idx;
            end
        end
        if (w_write) begin
            r_res_slot   <= SLOT_W'(w_sel_idx);
            r_res_status <= w_sel_status;
        end
        if (w_load_out) begin
            r_out_slot   <= r_res_slot;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = M_DATA_W'(r_out_slot);
    assign o_m_axis_tuser  = r_out_status;

endmodule

[sim/udp_flow_table_lru_chk.sv]
`timescale 1ns / 1ps

// Watches both stream channels, keeps its own flow table and compares every
// result transaction with the oldest lookup still outstanding.
module udp_flow_table_lru_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // frag_byte, inside_ip, inside_port, outside_ip, outside_port, source_mac
    input  logic [uftl_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // slot, zero padded
    input  logic [uftl_pkg::M_DATA_W-1:0] i_m_tdata,
    // status
    input  logic [uftl_pkg::STAT_W-1:0]   i_m_tuser,
    output int                            o_errors,
    output int                            o_pending
);

    import uftl_pkg::*;

    localparam int REPORT_CAP = 200;

    typedef struct packed {
        t_slot   slot;
        t_status status;
    } t_flow_result;

    // Shadow table; the MAC never reaches a result so it is not kept
    logic   flow_valid [ENTRIES];
    t_key   flow_key   [ENTRIES];
    t_stamp flow_stamp [ENTRIES];
    t_stamp use_count;

    t_flow_result lookups_due [$];
    int           err_count = 0;

    assign o_errors  = err_count;
    assign o_pending = lookups_due.size();

    // Look the header up in the shadow table and queue the result it must give
    task automatic lookup_flow(input logic [FRAG_W-1:0] frag, input t_key key);
        int           hit_idx;
        int           free_idx;
        int           pick;
        t_flow_result res;
        hit_idx  = -1;
        free_idx = -1;
        pick     = 0;
        if ((frag & FRAG_MASK) != '0) begin
            // fragment: dropped, table untouched
            res.slot   = '0;
            res.status = ST_DROP;
            lookups_due.push_back(res);
            return;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (!flow_valid[i]) begin
                free_idx = i;
            end else if (hit_idx < 0 && flow_key[i] == key) begin
                hit_idx = i;
            end
        end
        if (hit_idx >= 0) begin
            pick       = hit_idx;
            res.status = ST_HIT;
        end else begin
            if (free_idx >= 0) begin
                pick       = free_idx;
                res.status = ST_FREE;
            end else begin
                // oldest stamp, lowest index on a tie
                for (int i = 1; i < ENTRIES; i++) begin
                    if (flow_stamp[i] < flow_stamp[pick]) begin
                        pick = i;
                    end
                end
                res.status = ST_EVICT;
            end
            flow_valid[pick] = 1'b1;
            flow_key[pick]   = key;
        end
        // saturating use counter
        if (use_count != '1) begin
            use_count++;
        end
        flow_stamp[pick] = use_count;
        res.slot         = t_slot'(pick);
        lookups_due.push_back(res);
    endtask

    // Results first: a header accepted on this edge cannot answer on it
    always @(posedge i_clk) begin : mon
        t_flow_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                flow_valid[i] = 1'b0;
                flow_stamp[i] = '0;
            end
            use_count = '0;
            lookups_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (lookups_due.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_CAP) begin
                        $display({"%0t: unexpected result, expected none, ",
                                  "actual slot %0d status %0d"},
                                 $time, i_m_tdata, i_m_tuser);
                    end
                end else begin
                    want = lookups_due.pop_front();
                    if (i_m_tdata !== M_DATA_W'(want.slot)) begin
                        err_count++;
                        if (err_count <= REPORT_CAP) begin
                            $display("%0t: slot mismatch, expected %0d, actual %0d",
                                     $time, want.slot, i_m_tdata);
                        end
                    end
                    if (i_m_tuser !== want.status) begin
                        err_count++;
                        if (err_count <= REPORT_CAP) begin
                            $display("%0t: status mismatch, expected %0d (%s), actual %0d",
                                     $time, want.status, want.status.name(), i_m_tuser);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                lookup_flow(i_s_tdata[FRAG_W-1:0], i_s_tdata[FRAG_W +: KEY_W]);
            end
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

// Drives UDP headers into the flow table: a directed pass that fills the table,
// hits, evicts and drops fragments, then random headers drawn mostly from a
// small key pool so that hits, near misses and LRU evictions keep occurring.
module tb;

    import uftl_pkg::*;

    localparam int RANDOM_HEADERS = 1750;
    localparam int POOL_SIZE      = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [S_DATA_W-1:0] s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [M_DATA_W-1:0] m_data;
    logic [STAT_W-1:0]   m_user;

    int errors;
    int pending;
    bit calm        = 1'b0;
    int ready_left  = 0;
    int idle_cycles = 0;

    t_key key_pool [POOL_SIZE];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    udp_flow_table_lru uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    udp_flow_table_lru_chk chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .i_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .i_m_tdata  (m_data),
        .i_m_tuser  (m_user),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Result side back-pressure: mostly short stalls, the odd long one
    always @(negedge clk) begin : rx_stall
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) begin
            m_ready    = 1'b1;
            ready_left = 0;
        end else if (ready_left > 0) begin
            ready_left--;
        end else if (roll < 65) begin
            m_ready    = 1'b1;
            ready_left = $urandom_range(0, 7);
        end else if (roll < 95) begin
            m_ready    = 1'b0;
            ready_left = $urandom_range(0, 3);
        end else begin
            m_ready    = 1'b0;
            ready_left = $urandom_range(20, 60);
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_key make_key(input logic [IP_W-1:0] iip, input logic [PORT_W-1:0] iport,
                                      input logic [IP_W-1:0] oip, input logic [PORT_W-1:0] oport);
        return {oport, oip, iport, iip};
    endfunction

    // One header transaction; returns at the accepting edge
    task automatic send_header(input logic [FRAG_W-1:0] frag, input t_key key, input t_mac mac);
        @(negedge clk);
        s_valid = 1'b1;
        s_data  = {mac, key, frag};
        do @(posedge clk); while (!s_ready);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            @(negedge clk);
            s_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 50);
    endfunction

    function automatic t_key random_key();
        return t_key'({$urandom, $urandom, $urandom});
    endfunction

    initial begin : stim
        logic [FRAG_W-1:0] frag;
        t_key              key;
        t_mac              mac;
        int                roll;
        int                span;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = random_key();
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: drops, extremes, table fill, hit, LRU evictions
        send_header(8'h01, '0, '0);
        send_header(8'hff, '1, '1);
        send_header(8'h00, '0, '0);
        send_header(8'hc0, '1, '1);
        send_header(8'h40, '0, 48'h0123_4567_89ab);
        for (int i = 0; i < ENTRIES - 2; i++) begin
            send_header((i % 2 == 0) ? 8'h80 : 8'h00,
                        make_key(32'h0a00_0000 + i, 16'(1000 + i), 32'hc0a8_0001, 16'd53),
                        t_mac'(48'h02_00_00_00_00_00 + i));
        end
        send_header(8'h00, make_key(32'h0a00_00ff, 16'd4242, 32'h0808_0808, 16'd53), '1);
        send_header(8'h00, '1, '0);
        send_header(8'h20, make_key(32'h0a00_0003, 16'd1003, 32'hc0a8_0001, 16'd53), '0);
        send_header(8'h00, make_key(32'h0a00_0003, 16'd1003, 32'hc0a8_0001, 16'd53), '0);
        wait_drained();

        // Random: pooled keys, near misses, fresh keys and some fragments
        span = POOL_SIZE;
        for (int n = 0; n < RANDOM_HEADERS; n++) begin
            if (n % 50 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(8, POOL_SIZE);
                if (n % 350 == 0) begin
                    wait_drained();
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = random_key();
            end
            key = key_pool[$urandom_range(0, span - 1)];
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                // change a single key field
                case ($urandom_range(0, 3))
                    0: key[0 +: IP_W] = $urandom;
                    1: key[IP_W +: PORT_W] = PORT_W'($urandom);
                    2: key[IP_W + PORT_W +: IP_W] = $urandom;
                    default: key[2 * IP_W + PORT_W +: PORT_W] = PORT_W'($urandom);
                endcase
            end else if (roll < 25) begin
                key = random_key();
            end
            if ($urandom_range(0, 99) < 8) begin
                frag = {2'($urandom_range(0, 3)), 6'($urandom_range(1, 63))};
            end else begin
                frag = {2'($urandom_range(0, 3)), 6'b0};
            end
            mac = t_mac'({$urandom, $urandom});
            send_header(frag, key, mac);
            idle_for(pick_gap());
        end

        wait_drained();
        repeat (ENTRIES + 8) @(posedge clk);
        @(negedge clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
